@@ hdl/shift_beat_match_counter_top_defines.svh @@
// ----------------------------------------------------------------------------
// Shift beat match counter assertion macros
// Concurrent check helpers clocked on aclk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef SHIFT_BEAT_MATCH_COUNTER_TOP_DEFINES_SVH
`define SHIFT_BEAT_MATCH_COUNTER_TOP_DEFINES_SVH

// same-cycle implication
`define SBMC_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SBMC_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/sbmc_pkg.sv @@
// ----------------------------------------------------------------------------
// Shift beat match counter package
// Shared types, codes and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package sbmc_pkg;

    localparam int SYM_W     = 2;
    localparam int OFF_W     = 18;
    localparam int CNT_OUT_W = 9;
    localparam int BEAT_W    = 16;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int S_DATA_W  = 8;
    localparam int M_DATA_W  = 40;

    localparam logic [BEAT_W-1:0] BEAT_RESET = 16'd532;
    localparam logic [0:0] REG_BEAT_TABLE = 1'b0;

    typedef logic [SYM_W-1:0] sym_t;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_TEXT  = 2'd1,
        MODE_DRAIN = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        PH_LOAD  = 3'b001,
        PH_TEXT  = 3'b010,
        PH_DRAIN = 3'b100
    } phase_t;

    typedef struct packed {
        logic shift;
        logic load;
        sym_t sym;
    } cell_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/sbmc_cell.sv @@
// ----------------------------------------------------------------------------
// Shift beat match counter cell
// Holds one pattern symbol and the running count of one alignment; takes the
// count of its left neighbor and adds its own beat on every text symbol.
// ----------------------------------------------------------------------------
`default_nettype none

module sbmc_cell #(
    parameter int K  = 0,
    parameter int IW = 8,
    parameter int CW = 9
) (
    input  wire                           aclk,
    input  sbmc_pkg::cell_ctrl_t          ctrl,
    input  wire  [sbmc_pkg::BEAT_W-1:0]   beat_table,
    input  wire  [IW-1:0]                 wr_idx,
    input  wire  [CW-1:0]                 cnt_in,
    output logic [CW-1:0]                 cnt_out
);
    import sbmc_pkg::*;

    sym_t          pat_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          beat;

    assign beat     = beat_table[{pat_reg, ctrl.sym}];
    assign cnt_next = cnt_in + CW'(beat);
    assign cnt_out  = cnt_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load && (wr_idx == IW'(K))) begin
            pat_reg <= ctrl.sym;
        end
        if (ctrl.shift) begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/sbmc_apb.sv @@
// ----------------------------------------------------------------------------
// Shift beat match counter register port
// Holds the beat relation table behind a simple APB slave.
// ----------------------------------------------------------------------------
`default_nettype none

module sbmc_apb (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [sbmc_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire  [sbmc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [sbmc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output logic [sbmc_pkg::BEAT_W-1:0]        beat_table
);
    import sbmc_pkg::*;

    logic [BEAT_W-1:0] beat_reg;
    logic              hit;

    assign pready     = 1'b1;
    assign hit        = (paddr[APB_ADDR_W-1:2] == REG_BEAT_TABLE);
    assign beat_table = beat_reg;
    assign prdata     = hit ? APB_DATA_W'(beat_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_reg <= BEAT_RESET;
        end else if (psel && penable && pwrite && pready && hit) begin
            beat_reg <= pwdata[BEAT_W-1:0];
        end
    end

endmodule

`default_nettype wire

@@ hdl/shift_beat_match_counter_top.sv @@
// ----------------------------------------------------------------------------
// Shift beat match counter
// Sliding count of pattern-beats-text positions over a row of pattern cells.
// ----------------------------------------------------------------------------
//  channel  dir  handshake           payload
//  s_       in   s_tvalid/s_tready   tuser mode, tdata symbol, tlast last
//  m_       out  m_tvalid/m_tready   tdata offset/win_count/best, tlast final
//  apb      in   psel/penable        beat_table at address 0
//
//  A text request shifts the cell row when it is accepted. A request that
//  yields a result, text or drain, selects the tap cell and sets a pending
//  flag; the tap count is compared against the running best as it is output.
//  Reset clears control state only; cell counts need no clearing.
//  A result held by m_tready holds the next result pending with s_tready low.
// ----------------------------------------------------------------------------
`default_nettype none

`include "shift_beat_match_counter_top_defines.svh"

module shift_beat_match_counter_top #(
    parameter int PAT_MAX  = 256,
    parameter int TEXT_MAX = 262144
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire  [sbmc_pkg::S_DATA_W-1:0]      s_tdata,   // [1:0] symbol
    input  wire  [1:0]                         s_tuser,   // [1:0] mode
    input  wire                                s_tlast,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [sbmc_pkg::M_DATA_W-1:0]      m_tdata,   // [17:0] offset, [26:18] win_count,
                                                          // [35:27] best
    output logic                               m_tlast,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [sbmc_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire  [sbmc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [sbmc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import sbmc_pkg::*;

    localparam int LW = $clog2(PAT_MAX + 1);
    localparam int IW = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;
    localparam int CW = $clog2(PAT_MAX + 1);
    localparam int TW = $clog2(TEXT_MAX + 1);
    localparam int MW = (TW > LW) ? TW : LW;

    logic [BEAT_W-1:0] beat_table;
    cell_ctrl_t        ctrl;
    logic [CW-1:0]     cnt_chain [PAT_MAX];

    phase_t            phase_reg;
    logic [LW-1:0]     len_reg;
    logic [TW-1:0]     tp_reg;
    logic [TW-1:0]     no_reg;
    logic [CW-1:0]     best_reg;
    logic              pend_reg;
    logic              pend_end_reg;
    logic [IW-1:0]     tap_idx_reg;
    logic              m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic              m_tlast_reg;

    logic              acc;
    logic              is_load;
    logic              is_text;
    logic              is_drain;
    logic              len_room;
    logic [TW-1:0]     tp_inc;
    logic              text_end;
    logic              text_emit;
    logic              emit_go;
    logic              emit_fin;
    logic [CW-1:0]     tap_cnt;
    logic [CW-1:0]     best_next;
    logic [TW-1:0]     no_inc;

    sbmc_apb u_apb (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .beat_table (beat_table)
    );

    assign s_tready = !pend_reg;
    assign acc      = s_tvalid && s_tready;
    assign is_load  = acc && (s_tuser == MODE_LOAD)  && (phase_reg == PH_LOAD);
    assign is_text  = acc && (s_tuser == MODE_TEXT)  && (phase_reg == PH_TEXT);
    assign is_drain = acc && (s_tuser == MODE_DRAIN) && (phase_reg == PH_DRAIN);
    assign len_room = (len_reg != LW'(PAT_MAX));

    assign tp_inc    = tp_reg + TW'(1);
    assign text_end  = s_tlast || (tp_reg == TW'(TEXT_MAX - 1));
    assign text_emit = (MW'(tp_inc) >= MW'(len_reg));

    assign ctrl.shift = is_text;
    assign ctrl.load  = is_load && len_room;
    assign ctrl.sym   = s_tdata[SYM_W-1:0];

    genvar k;
    generate
        for (k = 0; k < PAT_MAX; k++) begin : g_cell
            logic [CW-1:0] cnt_left;
            if (k == 0) begin : g_head
                assign cnt_left = '0;
            end else begin : g_body
                assign cnt_left = cnt_chain[k-1];
            end
            sbmc_cell #(
                .K  (k),
                .IW (IW),
                .CW (CW)
            ) u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl),
                .beat_table (beat_table),
                .wr_idx     (len_reg[IW-1:0]),
                .cnt_in     (cnt_left),
                .cnt_out    (cnt_chain[k])
            );
        end
    endgenerate

    assign tap_cnt   = cnt_chain[tap_idx_reg];
    assign best_next = (tap_cnt > best_reg) ? tap_cnt : best_reg;
    assign no_inc    = no_reg + TW'(1);
    assign emit_go   = pend_reg && (!m_tvalid_reg || m_tready);
    assign emit_fin  = pend_end_reg && (no_inc == tp_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_LOAD;
            len_reg      <= '0;
            tp_reg       <= '0;
            no_reg       <= '0;
            best_reg     <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (is_load) begin
                if (len_room) begin
                    len_reg <= len_reg + LW'(1);
                end
                if (s_tlast) begin
                    phase_reg <= PH_TEXT;
                end
            end
            if (is_text) begin
                tp_reg <= tp_inc;
                if (text_emit) begin
                    pend_reg <= 1'b1;
                end
                if (text_end) begin
                    phase_reg <= PH_DRAIN;
                end
            end
            if (is_drain) begin
                pend_reg <= 1'b1;
            end
            if (emit_go) begin
                pend_reg     <= 1'b0;
                m_tvalid_reg <= 1'b1;
                best_reg     <= best_next;
                no_reg       <= no_inc;
                if (emit_fin) begin
                    phase_reg <= PH_LOAD;
                    len_reg   <= '0;
                    tp_reg    <= '0;
                    no_reg    <= '0;
                    best_reg  <= '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (is_text) begin
            pend_end_reg <= text_end;
            tap_idx_reg  <= IW'(len_reg - LW'(1));
        end
        if (is_drain) begin
            pend_end_reg <= 1'b1;
            tap_idx_reg  <= IW'(tp_reg - no_reg - TW'(1));
        end
        if (emit_go) begin
            m_tdata_reg <= M_DATA_W'({CNT_OUT_W'(best_next), CNT_OUT_W'(tap_cnt),
                                      OFF_W'(no_reg)});
            m_tlast_reg <= emit_fin;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    `SBMC_ASSERT_IMP(a_load_no_pend, phase_reg == PH_LOAD, !pend_reg, "result pending in load phase")
    `SBMC_ASSERT_IMP(a_offset_bound, 1'b1, no_reg <= tp_reg, "next offset beyond text position")
    `SBMC_ASSERT_NXT(a_best_holds, emit_go && !emit_fin, best_reg >= $past(tap_cnt), "best below count")
    `SBMC_ASSERT_NXT(a_final_clears, emit_go && emit_fin, (phase_reg == PH_LOAD) && (tp_reg == '0), "job not cleared")

endmodule

`default_nettype wire

@@ tb/shift_beat_match_counter_top_tb.sv @@
// ----------------------------------------------------------------------------
// Shift beat match counter testbench
// Streams pattern, text, drain and stray requests into the block, predicts
// every offset count with a local model of the cell row, and checks each
// result in order. Covers several beat tables, random handshake gaps on
// both channels, pattern overflow, and the largest counts.
// ----------------------------------------------------------------------------
`default_nettype none

module shift_beat_match_counter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sbmc_pkg::*;

    localparam int PAT_N          = 256;
    localparam int TEXT_N         = 262144;
    localparam int TARGET_ITEMS   = 1950;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [1:0] MODE_BAD = 2'd3;

    typedef struct {
        logic [1:0] mode;
        logic [1:0] sym;
        logic       last;
        bit         hold;
    } sym_req_t;

    typedef struct packed {
        logic [OFF_W-1:0]     offset;
        logic [CNT_OUT_W-1:0] win_count;
        logic [CNT_OUT_W-1:0] best;
        logic                 final_offset;
    } offset_count_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata  = '0;   // [1:0] symbol
    logic [1:0]            s_tuser  = '0;   // [1:0] mode
    logic                  s_tlast  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;         // [17:0] offset, [26:18] win_count,
                                            // [35:27] best
    logic                  m_tlast;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    shift_beat_match_counter_top #(
        .PAT_MAX (PAT_N),
        .TEXT_MAX(TEXT_N)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 aclk = ~aclk;

    sym_req_t      pending_reqs[$];
    offset_count_t expected_counts[$];
    int            mismatch_count = 0;
    int            quiet_cycles   = 0;
    int            wellformed_items = 0;
    bit            calm = 1'b0;
    int            send_gap = 0;
    int            recv_stall = 0;
    offset_count_t want;

    // local model of the cell row
    logic [BEAT_W-1:0] beat_tbl = BEAT_RESET;
    logic [1:0]        pat_mem[PAT_N];
    int unsigned       cnt_mem[PAT_N];
    int unsigned       pat_len  = 0;
    int unsigned       text_pos = 0;
    int unsigned       next_off = 0;
    int unsigned       best_cnt = 0;
    phase_t            ph = PH_LOAD;

    initial begin
        foreach (cnt_mem[i]) cnt_mem[i] = 0;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    function automatic void restart_job();
        pat_len  = 0;
        text_pos = 0;
        next_off = 0;
        best_cnt = 0;
        ph       = PH_LOAD;
    endfunction

    function automatic bit emit_offset(input bit ended);
        offset_count_t r;
        int unsigned   c;
        c = cnt_mem[next_off % PAT_N];
        if (c > best_cnt)
            best_cnt = c;
        r.offset       = next_off[OFF_W-1:0];
        r.win_count    = c[CNT_OUT_W-1:0];
        r.best         = best_cnt[CNT_OUT_W-1:0];
        r.final_offset = ended && (next_off + 1 == text_pos);
        next_off++;
        expected_counts.push_back(r);
        return r.final_offset;
    endfunction

    function automatic void step_match_model(input sym_req_t req);
        int unsigned p;
        bit          ended;
        case (req.mode)
            MODE_LOAD: begin
                if (ph == PH_LOAD) begin
                    if (pat_len < PAT_N) begin
                        pat_mem[pat_len] = req.sym;
                        pat_len++;
                    end
                    if (req.last)
                        ph = PH_TEXT;
                end
            end
            MODE_TEXT: begin
                if (ph == PH_TEXT) begin
                    p = text_pos;
                    cnt_mem[p % PAT_N] = 0;
                    for (int unsigned k = 0; k < pat_len && k <= p; k++)
                        cnt_mem[(p - k) % PAT_N] += beat_tbl[{pat_mem[k], req.sym}];
                    text_pos = p + 1;
                    ended = req.last || text_pos >= TEXT_N;
                    if (text_pos >= pat_len)
                        void'(emit_offset(ended));
                    if (ended) begin
                        if (next_off >= text_pos)
                            restart_job();
                        else
                            ph = PH_DRAIN;
                    end
                end
            end
            MODE_DRAIN: begin
                if (ph == PH_DRAIN && emit_offset(1'b1))
                    restart_job();
            end
            default: ;
        endcase
    endfunction

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                step_match_model(pending_reqs.pop_front());
                send_gap = calm ? 0 : $urandom_range(0, 6);
            end else if (!s_tvalid && send_gap != 0) begin
                send_gap--;
            end
            if (s_tvalid && !s_tready) begin
                // hold the current request
            end else if (pending_reqs.size() != 0 && send_gap == 0 &&
                         !(pending_reqs[0].hold && expected_counts.size() != 0)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= S_DATA_W'(pending_reqs[0].sym);
                s_tuser  <= pending_reqs[0].mode;
                s_tlast  <= pending_reqs[0].last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_counts.size() == 0) begin
                    report_mismatch($sformatf("result with no request pending, offset %0d",
                                              m_tdata[OFF_W-1:0]));
                end else begin
                    want = expected_counts.pop_front();
                    if (m_tdata[OFF_W-1:0] !== want.offset ||
                        m_tdata[OFF_W+CNT_OUT_W-1:OFF_W] !== want.win_count ||
                        m_tdata[OFF_W+2*CNT_OUT_W-1:OFF_W+CNT_OUT_W] !== want.best ||
                        m_tlast !== want.final_offset)
                        report_mismatch($sformatf(
                            "got off %0d cnt %0d best %0d last %b, want off %0d cnt %0d best %0d last %b",
                            m_tdata[OFF_W-1:0], m_tdata[OFF_W+CNT_OUT_W-1:OFF_W],
                            m_tdata[OFF_W+2*CNT_OUT_W-1:OFF_W+CNT_OUT_W], m_tlast,
                            want.offset, want.win_count, want.best, want.final_offset));
                end
                recv_stall = calm ? 0 : $urandom_range(0, 6);
            end else if (recv_stall != 0) begin
                recv_stall--;
            end
            m_tready <= (recv_stall == 0);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("shift_beat_match_counter_top regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_req(input logic [1:0] mode, input logic [1:0] sym,
                            input logic last, input bit hold);
        sym_req_t r;
        r.mode = mode;
        r.sym  = sym;
        r.last = last;
        r.hold = hold;
        pending_reqs.push_back(r);
    endtask

    // stray request that the current phase ignores
    task automatic add_noise(input logic [1:0] active_mode, input int pct);
        logic [1:0] m;
        if ($urandom_range(0, 99) < pct) begin
            m = active_mode;
            while (m == active_mode)
                m = 2'($urandom_range(0, 3));
            push_req(m, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 1'b0);
        end
    endtask

    function automatic logic [1:0] pick_sym(input int fixed);
        return (fixed < 0) ? 2'($urandom_range(0, 3)) : 2'(fixed);
    endfunction

    task automatic gen_job(input int plen, input int tlen, input int psym,
                           input int tsym, input int pct);
        int p_eff;
        int t_eff;
        int pending;
        p_eff   = (plen > PAT_N) ? PAT_N : plen;
        t_eff   = (tlen > TEXT_N) ? TEXT_N : tlen;
        pending = (t_eff >= p_eff) ? p_eff - 1 : t_eff;
        for (int i = 0; i < plen; i++) begin
            add_noise(MODE_LOAD, pct);
            push_req(MODE_LOAD, pick_sym(psym), i == plen - 1,
                     i == 0 && $urandom_range(0, 7) == 0);
        end
        for (int i = 0; i < tlen; i++) begin
            add_noise(MODE_TEXT, pct);
            push_req(MODE_TEXT, pick_sym(tsym), i == tlen - 1, 1'b0);
        end
        for (int i = 0; i < pending; i++) begin
            add_noise(MODE_DRAIN, pct);
            push_req(MODE_DRAIN, pick_sym(-1), 1'($urandom_range(0, 1)), 1'b0);
        end
        if ($urandom_range(0, 9) == 0)
            push_req(MODE_DRAIN, pick_sym(-1), 1'($urandom_range(0, 1)), 1'b0);
        wellformed_items += plen + tlen + pending;
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || s_tvalid || expected_counts.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_beat_table(input logic [BEAT_W-1:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_BEAT_TABLE, 2'b00};
        pwdata  <= APB_DATA_W'(val);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        beat_tbl = val;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata[BEAT_W-1:0] !== val)
            report_mismatch($sformatf("beat_table read %h, want %h", prdata[BEAT_W-1:0], val));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    int plen;
    int tlen;

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: strays in every phase, short and exact texts
        push_req(MODE_DRAIN, 2'd0, 1'b0, 1'b1);
        push_req(MODE_BAD, 2'd3, 1'b1, 1'b0);
        push_req(MODE_TEXT, 2'd1, 1'b1, 1'b0);
        push_req(MODE_LOAD, 2'd0, 1'b0, 1'b0);
        push_req(MODE_LOAD, 2'd1, 1'b0, 1'b0);
        push_req(MODE_LOAD, 2'd2, 1'b0, 1'b0);
        push_req(MODE_LOAD, 2'd3, 1'b1, 1'b0);
        push_req(MODE_LOAD, 2'd1, 1'b1, 1'b0);
        push_req(MODE_DRAIN, 2'd0, 1'b0, 1'b0);
        push_req(MODE_TEXT, 2'd2, 1'b0, 1'b0);
        push_req(MODE_TEXT, 2'd0, 1'b0, 1'b0);
        push_req(MODE_TEXT, 2'd1, 1'b0, 1'b0);
        push_req(MODE_TEXT, 2'd3, 1'b0, 1'b0);
        push_req(MODE_TEXT, 2'd2, 1'b0, 1'b0);
        push_req(MODE_TEXT, 2'd1, 1'b1, 1'b0);
        push_req(MODE_TEXT, 2'd0, 1'b1, 1'b0);
        push_req(MODE_LOAD, 2'd2, 1'b0, 1'b0);
        repeat (3) push_req(MODE_DRAIN, 2'd3, 1'b1, 1'b0);
        push_req(MODE_DRAIN, 2'd1, 1'b0, 1'b1);
        gen_job(4, 2, -1, -1, 0);
        gen_job(1, 1, -1, -1, 0);
        wait_idle();

        // overlong pattern, full counts
        gen_job(300, 260, 0, 2, 0);
        wait_idle();

        for (int phase_idx = 0; phase_idx < 5; phase_idx++) begin
            case (phase_idx)
                1:       write_beat_table('0);
                2:       write_beat_table('1);
                default: write_beat_table(BEAT_W'($urandom_range(0, 65535)));
            endcase
            calm = (phase_idx == 3);
            while (wellformed_items < TARGET_ITEMS * (phase_idx + 1) / 5) begin
                case ($urandom_range(0, 39))
                    0:       plen = $urandom_range(250, 270);
                    1, 2, 3: plen = $urandom_range(13, 64);
                    default: plen = $urandom_range(1, 12);
                endcase
                tlen = ($urandom_range(0, 4) == 0) ? $urandom_range(31, 80)
                                                   : $urandom_range(1, 30);
                gen_job(plen, tlen, -1, -1, ($urandom_range(0, 3) == 0) ? 0 : 15);
            end
            wait_idle();
        end

        if (mismatch_count == 0)
            $display("shift_beat_match_counter_top regression: pass");
        else
            $display("shift_beat_match_counter_top regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
